>>> rtl/depe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package depe_pkg;

  localparam int unsigned MAX_EDGES = 4096;
  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned IDX_W     = $clog2(MAX_EDGES);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned NODE_W    = 10;
  localparam int unsigned IMG_W     = 8;
  localparam int unsigned OUT_W     = 12;

  localparam logic [CNT_W-1:0]  EDGE_LIM = CNT_W'(MAX_EDGES);
  localparam logic [NODE_W:0]   NODE_LIM = (NODE_W + 1)'(MAX_NODES);
  localparam logic [IMG_W-1:0]  IMG_MIN  = {1'b1, {(IMG_W - 1){1'b0}}};

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0]       center;
    logic [NODE_W-1:0]       neighbor;
    logic signed [IMG_W-1:0] img_a;
    logic signed [IMG_W-1:0] img_b;
    logic signed [IMG_W-1:0] img_c;
  } edge_t;

  typedef struct packed {
    logic [OUT_W-1:0] dir_idx;
    logic [OUT_W-1:0] und_idx;
    logic             is_new;
    logic             ovf;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/depe_match.sv
`timescale 1ns / 1ps
`default_nettype none

module depe_match (
  input  depe_pkg::edge_t stored_i,
  input  depe_pkg::edge_t probe_i,
  output logic            match_o
);

  import depe_pkg::*;

  // stored component must be the exact negation; the most negative value has none
  function automatic logic comp_rev(input logic [IMG_W-1:0] s, input logic [IMG_W-1:0] a);
    logic [IMG_W-1:0] na;
    na = ~a + IMG_W'(1);
    return (a != IMG_MIN) && (s == na);
  endfunction

  assign match_o = comp_rev(stored_i.img_a, probe_i.img_a) &&
                   comp_rev(stored_i.img_b, probe_i.img_b) &&
                   comp_rev(stored_i.img_c, probe_i.img_c) &&
                   (stored_i.center   == probe_i.neighbor) &&
                   (stored_i.neighbor == probe_i.center);

endmodule

`default_nettype wire

>>> rtl/directed_edge_pairing_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Pairs directed edges into undirected edges. An add item is numbered in
// arrival order and compared against the first directed edge of each stored
// undirected edge, one table entry per cycle through a single comparator fed
// from the table memory's read port, in creation order; the first reverse
// match wins, otherwise a new undirected edge is written. The block takes no
// new item until the current add item has loaded its result into the output
// register. A dropped item (table full or node out of range) gives a result
// flagged as overflow; a clear item gives no result. A result that finds the
// output register still occupied holds the block until that register is taken.
// Input is taken while a finished result still waits in the output register.

module directed_edge_pairing_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [depe_pkg::NODE_W-1:0]       center_node_i,
  input  logic [depe_pkg::NODE_W-1:0]       neighbor_node_i,
  input  logic signed [depe_pkg::IMG_W-1:0] image_a_i,
  input  logic signed [depe_pkg::IMG_W-1:0] image_b_i,
  input  logic signed [depe_pkg::IMG_W-1:0] image_c_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [depe_pkg::OUT_W-1:0]        directed_index_o,
  output logic [depe_pkg::OUT_W-1:0]        undir_index_o,
  output logic                              is_new_o,
  output logic                              overflow_o
);

  import depe_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] dcnt_q, dcnt_d;
  logic [CNT_W-1:0] ucnt_q, ucnt_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  edge_t            edge_q, edge_d;
  res_t             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q;
  edge_t            rd_data_q;
  logic             rd_en, wr_en, out_load, hit;

  edge_t pair_mem [MAX_EDGES];

  depe_match u_match (
    .stored_i (rd_data_q),
    .probe_i  (edge_q),
    .match_o  (hit)
  );

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    dcnt_d    = dcnt_q;
    ucnt_d    = ucnt_q;
    ptr_d     = ptr_q;
    rd_vld_d  = 1'b0;
    cmp_idx_d = cmp_idx_q;
    edge_d    = edge_q;
    res_d     = res_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_CLEAR) begin
            dcnt_d = '0;
            ucnt_d = '0;
          end else begin
            edge_d = '{center: center_node_i, neighbor: neighbor_node_i,
                       img_a: image_a_i, img_b: image_b_i, img_c: image_c_i};
            ptr_d  = '0;
            if ((dcnt_q >= EDGE_LIM) || ({1'b0, center_node_i} >= NODE_LIM) ||
                ({1'b0, neighbor_node_i} >= NODE_LIM)) begin
              res_d   = '{dir_idx: '0, und_idx: '0, is_new: 1'b0, ovf: 1'b1};
              state_d = S_PUSH;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (ptr_q < ucnt_q) begin
          rd_en     = 1'b1;
          rd_vld_d  = 1'b1;
          ptr_d     = ptr_q + CNT_W'(1);
          cmp_idx_d = ptr_q[IDX_W-1:0];
        end
        if (rd_vld_q && hit) begin
          res_d   = '{dir_idx: OUT_W'(dcnt_q), und_idx: OUT_W'(cmp_idx_q),
                      is_new: 1'b0, ovf: 1'b0};
          dcnt_d  = dcnt_q + CNT_W'(1);
          state_d = S_PUSH;
        end else if (ptr_q >= ucnt_q) begin
          // last entry compared without a match
          if (ucnt_q >= EDGE_LIM) begin
            res_d = '{dir_idx: '0, und_idx: '0, is_new: 1'b0, ovf: 1'b1};
          end else begin
            wr_en  = 1'b1;
            res_d  = '{dir_idx: OUT_W'(dcnt_q), und_idx: OUT_W'(ucnt_q),
                       is_new: 1'b1, ovf: 1'b0};
            ucnt_d = ucnt_q + CNT_W'(1);
            dcnt_d = dcnt_q + CNT_W'(1);
          end
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dcnt_q      <= '0;
      ucnt_q      <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dcnt_q      <= dcnt_d;
      ucnt_q      <= ucnt_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q    <= edge_d;
    res_q     <= res_d;
    cmp_idx_q <= cmp_idx_d;
    if (out_load) begin
      out_res_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pair_mem[ucnt_q[IDX_W-1:0]] <= edge_q;
    end
    if (rd_en) begin
      rd_data_q <= pair_mem[ptr_q[IDX_W-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign directed_index_o = out_res_q.dir_idx;
  assign undir_index_o    = out_res_q.und_idx;
  assign is_new_o         = out_res_q.is_new;
  assign overflow_o       = out_res_q.ovf;

  a_ucnt_le_dcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucnt_q <= dcnt_q)
    else $error("undirected count above directed count");

  a_new_not_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && overflow_o))
    else $error("result both new and dropped");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && rd_vld_q |-> ({1'b0, cmp_idx_q} < ucnt_q))
    else $error("compare beyond stored entries");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_CLEAR) |=> (dcnt_q == '0) && (ucnt_q == '0))
    else $error("clear item left counts");

endmodule

`default_nettype wire
